// ===== sv/pftr_pkg.sv =====
// ----------------------------------------------------------------------------
// pftr_pkg: page frame table shared definitions
// Request codes, status and action codes, register indexes, rule codes,
// sequencer states, and the result word and divider request records.
// ----------------------------------------------------------------------------
package pftr_pkg;

	localparam logic [2:0] MODE_PIN   = 3'd0;
	localparam logic [2:0] MODE_UNPIN = 3'd1;
	localparam logic [2:0] MODE_DIRTY = 3'd2;
	localparam logic [2:0] MODE_FORCE = 3'd3;
	localparam logic [2:0] MODE_FLUSH = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOVICTIM = 2'd1;
	localparam logic [1:0] ST_ABSENT   = 2'd2;
	localparam logic [1:0] ST_FLUSHERR = 2'd3;

	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_FETCH = 2'd1;
	localparam logic [1:0] ACT_WBACK = 2'd2;

	localparam logic [1:0] REG_FRAMES = 2'd0;
	localparam logic [1:0] REG_RULE   = 2'd1;
	localparam logic [1:0] REG_KRANK  = 2'd2;

	localparam logic [1:0] RULE_FIFO = 2'd0;
	localparam logic [1:0] RULE_LRU  = 2'd1;
	localparam logic [1:0] RULE_KTH  = 2'd2;

	localparam int IO_PAGE_W = 24;

	typedef enum logic [16:0] {
		S_IDLE  = 17'b00000000000000001,
		S_HIT   = 17'b00000000000000010,
		S_FREE  = 17'b00000000000000100,
		S_MODW  = 17'b00000000000001000,
		S_FIFO  = 17'b00000000000010000,
		S_LRU   = 17'b00000000000100000,
		S_KCNT  = 17'b00000000001000000,
		S_KOUT  = 17'b00000000010000000,
		S_KIN   = 17'b00000000100000000,
		S_EVICT = 17'b00000001000000000,
		S_LOAD  = 17'b00000010000000000,
		S_UNPIN = 17'b00000100000000000,
		S_DIRTY = 17'b00001000000000000,
		S_FPRE  = 17'b00010000000000000,
		S_FORCE = 17'b00100000000000000,
		S_FLUSH = 17'b01000000000000000,
		S_FINAL = 17'b10000000000000000
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [31:0]          dividend;
	} div_req_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [1:0]           action;
		logic [3:0]           frame;
		logic [IO_PAGE_W-1:0] page;
		logic                 last;
	} result_t;

endpackage

// ===== sv/page_frame_table_replacement.sv =====
// ----------------------------------------------------------------------------
// page_frame_table_replacement: buffer pool frame table with replacement
// Frame table with pin, unpin, mark dirty, force and flush requests, and
// FIFO, LRU or k-th least recent victim choice.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy stays high
// until its last result word. Each result word is shown for one cycle with
// result_strobe and must be taken then, since the receiver cannot stall.
// The sequencer visits one frame per cycle, except while FIFO waits for the
// start remainder from the divider. A pin scans the table for the page and
// then for a free frame. When a victim is needed, FIFO scans on from the
// start remainder, LRU scans once, and the k-th rule compares each unpinned
// frame with all others; a dirty victim is written back before the fetch.
// Unpin, mark dirty, force and flush scan the table for their frames.
module page_frame_table_replacement #(
	parameter int FRAMES    = 16,
	parameter int PAGE_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [23:0] page_number,
	output logic        result_strobe,
	output logic [1:0]  status,
	output logic [1:0]  action,
	output logic [3:0]  frame_index,
	output logic [23:0] io_page,
	output logic        is_last,
	output logic [31:0] reads_done,
	output logic [31:0] writes_done
);

	localparam int NW = $clog2(FRAMES + 1);
	localparam int FW = $clog2(FRAMES);
	localparam int PW = PAGE_BITS;
	localparam logic [15:0] PIN_MAX = 16'hFFFF;

	logic [PW-1:0] fpage_q  [FRAMES];
	logic          fvalid_q [FRAMES];
	logic          fdirty_q [FRAMES];
	logic [15:0]   fpins_q  [FRAMES];
	logic [31:0]   fstamp_q [FRAMES];
	logic [31:0]   stamp_cnt_q;
	logic [31:0]   fetch_cnt_q;
	logic [31:0]   wb_cnt_q;

	logic [4:0] frames_q;
	logic [1:0] rule_q;
	logic [4:0] krank_q;

	pftr_pkg::state_t state_q;
	logic [PW-1:0] page_q;
	logic [NW-1:0] n_q;
	logic [FW-1:0] idx_q;
	logic [FW-1:0] ki_q;
	logic [FW-1:0] best_q;
	logic [FW-1:0] first_q;
	logic [FW-1:0] lastm_q;
	logic [NW-1:0] cnt_q;
	logic [NW-1:0] less_q;
	logic [NW-1:0] le_q;
	logic [NW-1:0] k_q;
	logic [31:0]   stamp_i_q;
	logic          have_q;
	logic          found_q;
	logic          written_q;
	logic          failed_q;
	logic          div_go_q;

	pftr_pkg::result_t res_q;
	logic              strobe_q;

	pftr_pkg::div_req_t div_req;
	logic               div_done;
	logic [FW-1:0]      div_rem;

	logic [NW-1:0]    n_act;
	logic [PW-1:0]    page_in;
	logic [PW+23:0]   page_ext;
	logic             idx_last;
	logic             match;
	logic             unpinned;
	logic [NW-1:0]    less_nx;
	logic [NW-1:0]    le_nx;
	logic [NW-1:0]    k_clamp;
	logic [FW-1:0]    idx_inc;

	assign div_req.start    = div_go_q;
	assign div_req.dividend = fetch_cnt_q;

	pftr_divmod #(.FRAMES(FRAMES)) u_divmod (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (div_req),
		.divisor   (n_q),
		.done      (div_done),
		.remainder (div_rem)
	);

	function automatic pftr_pkg::result_t mk_res(logic [1:0] st, logic [1:0] ac,
			logic [FW-1:0] fr, logic [PW-1:0] pg, logic last);
		pftr_pkg::result_t r;
		logic [FW+3:0]     fr_ext;
		logic [PW+23:0]    pg_ext;
		fr_ext   = {4'b0, fr};
		pg_ext   = {24'b0, pg};
		r.status = st;
		r.action = ac;
		r.frame  = fr_ext[3:0];
		r.page   = pg_ext[23:0];
		r.last   = last;
		return r;
	endfunction

	always_comb begin
		if (frames_q == 5'd0) begin
			n_act = NW'(1);
		end else if (32'(frames_q) > 32'(FRAMES)) begin
			n_act = NW'(FRAMES);
		end else begin
			n_act = NW'(frames_q);
		end
	end

	always_comb begin
		if (krank_q == 5'd0) begin
			k_clamp = NW'(1);
		end else if (32'(krank_q) > 32'(cnt_q)) begin
			k_clamp = cnt_q;
		end else begin
			k_clamp = NW'(krank_q);
		end
	end

	assign page_ext = {{PW{1'b0}}, page_number};
	assign page_in  = page_ext[PW-1:0];
	assign idx_last = (NW'(idx_q) == n_q - NW'(1));
	assign idx_inc  = idx_q + FW'(1);
	assign match    = fvalid_q[idx_q] && (fpage_q[idx_q] == page_q);
	assign unpinned = (fpins_q[idx_q] == 16'd0);
	assign less_nx  = less_q + NW'(unpinned && (fstamp_q[idx_q] < stamp_i_q));
	assign le_nx    = le_q + NW'(unpinned && (fstamp_q[idx_q] <= stamp_i_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= 5'd16;
			rule_q   <= pftr_pkg::RULE_FIFO;
			krank_q  <= 5'd1;
		end else if (cfg_write) begin
			case (cfg_index)
				pftr_pkg::REG_FRAMES: frames_q <= cfg_data;
				pftr_pkg::REG_RULE:   rule_q   <= cfg_data[1:0];
				pftr_pkg::REG_KRANK:  krank_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pftr_pkg::S_IDLE;
			strobe_q    <= 1'b0;
			div_go_q    <= 1'b0;
			stamp_cnt_q <= '0;
			fetch_cnt_q <= '0;
			wb_cnt_q    <= '0;
			for (int f = 0; f < FRAMES; f++) begin
				fpage_q[f]  <= '0;
				fvalid_q[f] <= 1'b0;
				fdirty_q[f] <= 1'b0;
				fpins_q[f]  <= '0;
				fstamp_q[f] <= '0;
			end
		end else begin
			strobe_q <= 1'b0;
			div_go_q <= 1'b0;
			case (state_q)
				pftr_pkg::S_IDLE: begin
					if (start) begin
						page_q    <= page_in;
						n_q       <= n_act;
						idx_q     <= '0;
						found_q   <= 1'b0;
						written_q <= 1'b0;
						failed_q  <= 1'b0;
						case (mode)
							pftr_pkg::MODE_PIN:   state_q <= pftr_pkg::S_HIT;
							pftr_pkg::MODE_UNPIN: state_q <= pftr_pkg::S_UNPIN;
							pftr_pkg::MODE_DIRTY: state_q <= pftr_pkg::S_DIRTY;
							pftr_pkg::MODE_FORCE: state_q <= pftr_pkg::S_FPRE;
							pftr_pkg::MODE_FLUSH: state_q <= pftr_pkg::S_FLUSH;
							default: begin
								strobe_q <= 1'b1;
								res_q    <= mk_res(pftr_pkg::ST_ABSENT, pftr_pkg::ACT_NONE,
									'0, page_in, 1'b1);
							end
						endcase
					end
				end
				pftr_pkg::S_HIT: begin
					if (match) begin
						stamp_cnt_q     <= stamp_cnt_q + 32'd1;
						fstamp_q[idx_q] <= stamp_cnt_q + 32'd1;
						if (fpins_q[idx_q] < PIN_MAX) begin
							fpins_q[idx_q] <= fpins_q[idx_q] + 16'd1;
						end
						strobe_q <= 1'b1;
						res_q    <= mk_res(pftr_pkg::ST_OK, pftr_pkg::ACT_NONE, idx_q,
							page_q, 1'b1);
						state_q  <= pftr_pkg::S_IDLE;
					end else if (idx_last) begin
						idx_q   <= '0;
						state_q <= pftr_pkg::S_FREE;
					end else begin
						idx_q <= idx_inc;
					end
				end
				pftr_pkg::S_FREE: begin
					if (!fvalid_q[idx_q]) begin
						fetch_cnt_q     <= fetch_cnt_q + 32'd1;
						stamp_cnt_q     <= stamp_cnt_q + 32'd1;
						fstamp_q[idx_q] <= stamp_cnt_q + 32'd1;
						fpage_q[idx_q]  <= page_q;
						fvalid_q[idx_q] <= 1'b1;
						fdirty_q[idx_q] <= 1'b0;
						fpins_q[idx_q]  <= 16'd1;
						strobe_q <= 1'b1;
						res_q    <= mk_res(pftr_pkg::ST_OK, pftr_pkg::ACT_FETCH, idx_q,
							page_q, 1'b1);
						state_q  <= pftr_pkg::S_IDLE;
					end else if (idx_last) begin
						idx_q  <= '0;
						cnt_q  <= '0;
						have_q <= 1'b0;
						case (rule_q)
							pftr_pkg::RULE_FIFO: begin
								div_go_q <= 1'b1;
								state_q  <= pftr_pkg::S_MODW;
							end
							pftr_pkg::RULE_LRU: state_q <= pftr_pkg::S_LRU;
							pftr_pkg::RULE_KTH: state_q <= pftr_pkg::S_KCNT;
							default: begin
								strobe_q <= 1'b1;
								res_q    <= mk_res(pftr_pkg::ST_NOVICTIM, pftr_pkg::ACT_NONE,
									'0, page_q, 1'b1);
								state_q  <= pftr_pkg::S_IDLE;
							end
						endcase
					end else begin
						idx_q <= idx_inc;
					end
				end
				pftr_pkg::S_MODW: begin
					if (div_done) begin
						idx_q   <= div_rem;
						state_q <= pftr_pkg::S_FIFO;
					end
				end
				pftr_pkg::S_FIFO: begin
					if (unpinned) begin
						state_q <= pftr_pkg::S_EVICT;
					end else if (cnt_q == n_q - NW'(1)) begin
						strobe_q <= 1'b1;
						res_q    <= mk_res(pftr_pkg::ST_NOVICTIM, pftr_pkg::ACT_NONE, '0,
							page_q, 1'b1);
						state_q  <= pftr_pkg::S_IDLE;
					end else begin
						cnt_q <= cnt_q + NW'(1);
						idx_q <= idx_last ? '0 : idx_inc;
					end
				end
				pftr_pkg::S_LRU: begin
					logic take;
					take = unpinned && (!have_q || (fstamp_q[idx_q] < stamp_i_q));
					if (take) begin
						have_q    <= 1'b1;
						best_q    <= idx_q;
						stamp_i_q <= fstamp_q[idx_q];
					end
					if (idx_last) begin
						if (take || have_q) begin
							idx_q   <= take ? idx_q : best_q;
							state_q <= pftr_pkg::S_EVICT;
						end else begin
							strobe_q <= 1'b1;
							res_q    <= mk_res(pftr_pkg::ST_NOVICTIM, pftr_pkg::ACT_NONE,
								'0, page_q, 1'b1);
							state_q  <= pftr_pkg::S_IDLE;
						end
					end else begin
						idx_q <= idx_inc;
					end
				end
				pftr_pkg::S_KCNT: begin
					if (idx_last) begin
						if (cnt_q == '0 && !unpinned) begin
							strobe_q <= 1'b1;
							res_q    <= mk_res(pftr_pkg::ST_NOVICTIM, pftr_pkg::ACT_NONE,
								'0, page_q, 1'b1);
							state_q  <= pftr_pkg::S_IDLE;
						end else begin
							cnt_q   <= cnt_q + NW'(unpinned);
							idx_q   <= '0;
							ki_q    <= '0;
							state_q <= pftr_pkg::S_KOUT;
						end
					end else begin
						cnt_q <= cnt_q + NW'(unpinned);
						idx_q <= idx_inc;
					end
				end
				pftr_pkg::S_KOUT: begin
					k_q <= k_clamp;
					if (unpinned) begin
						stamp_i_q <= fstamp_q[idx_q];
						less_q    <= '0;
						le_q      <= '0;
						idx_q     <= '0;
						state_q   <= pftr_pkg::S_KIN;
					end else if (idx_last) begin
						strobe_q <= 1'b1;
						res_q    <= mk_res(pftr_pkg::ST_NOVICTIM, pftr_pkg::ACT_NONE, '0,
							page_q, 1'b1);
						state_q  <= pftr_pkg::S_IDLE;
					end else begin
						idx_q <= idx_inc;
						ki_q  <= idx_inc;
					end
				end
				pftr_pkg::S_KIN: begin
					less_q <= less_nx;
					le_q   <= le_nx;
					if (idx_last) begin
						if (less_nx < k_q && k_q <= le_nx) begin
							idx_q   <= ki_q;
							state_q <= pftr_pkg::S_EVICT;
						end else if (NW'(ki_q) == n_q - NW'(1)) begin
							strobe_q <= 1'b1;
							res_q    <= mk_res(pftr_pkg::ST_NOVICTIM, pftr_pkg::ACT_NONE,
								'0, page_q, 1'b1);
							state_q  <= pftr_pkg::S_IDLE;
						end else begin
							ki_q    <= ki_q + FW'(1);
							idx_q   <= ki_q + FW'(1);
							state_q <= pftr_pkg::S_KOUT;
						end
					end else begin
						idx_q <= idx_inc;
					end
				end
				pftr_pkg::S_EVICT, pftr_pkg::S_LOAD: begin
					strobe_q <= 1'b1;
					if (state_q == pftr_pkg::S_EVICT && fdirty_q[idx_q]) begin
						fdirty_q[idx_q] <= 1'b0;
						wb_cnt_q <= wb_cnt_q + 32'd1;
						res_q    <= mk_res(pftr_pkg::ST_OK, pftr_pkg::ACT_WBACK, idx_q,
							fpage_q[idx_q], 1'b0);
						state_q  <= pftr_pkg::S_LOAD;
					end else begin
						fetch_cnt_q     <= fetch_cnt_q + 32'd1;
						stamp_cnt_q     <= stamp_cnt_q + 32'd1;
						fstamp_q[idx_q] <= stamp_cnt_q + 32'd1;
						fpage_q[idx_q]  <= page_q;
						fvalid_q[idx_q] <= 1'b1;
						fdirty_q[idx_q] <= 1'b0;
						fpins_q[idx_q]  <= 16'd1;
						res_q    <= mk_res(pftr_pkg::ST_OK, pftr_pkg::ACT_FETCH, idx_q,
							page_q, 1'b1);
						state_q  <= pftr_pkg::S_IDLE;
					end
				end
				pftr_pkg::S_UNPIN: begin
					if (match) begin
						strobe_q <= 1'b1;
						if (!unpinned) begin
							fpins_q[idx_q] <= fpins_q[idx_q] - 16'd1;
							res_q <= mk_res(pftr_pkg::ST_OK, pftr_pkg::ACT_NONE, idx_q,
								page_q, 1'b1);
						end else begin
							res_q <= mk_res(pftr_pkg::ST_ABSENT, pftr_pkg::ACT_NONE, idx_q,
								page_q, 1'b1);
						end
						state_q <= pftr_pkg::S_IDLE;
					end else if (idx_last) begin
						strobe_q <= 1'b1;
						res_q    <= mk_res(pftr_pkg::ST_ABSENT, pftr_pkg::ACT_NONE, '0,
							page_q, 1'b1);
						state_q  <= pftr_pkg::S_IDLE;
					end else begin
						idx_q <= idx_inc;
					end
				end
				pftr_pkg::S_DIRTY: begin
					if (match) begin
						fdirty_q[idx_q] <= 1'b1;
						if (!found_q) begin
							first_q <= idx_q;
						end
						found_q <= 1'b1;
					end
					if (idx_last) begin
						strobe_q <= 1'b1;
						if (found_q) begin
							res_q <= mk_res(pftr_pkg::ST_OK, pftr_pkg::ACT_NONE, first_q,
								page_q, 1'b1);
						end else if (match) begin
							res_q <= mk_res(pftr_pkg::ST_OK, pftr_pkg::ACT_NONE, idx_q,
								page_q, 1'b1);
						end else begin
							res_q <= mk_res(pftr_pkg::ST_ABSENT, pftr_pkg::ACT_NONE, '0,
								page_q, 1'b1);
						end
						state_q <= pftr_pkg::S_IDLE;
					end else begin
						idx_q <= idx_inc;
					end
				end
				pftr_pkg::S_FPRE: begin
					if (match) begin
						found_q <= 1'b1;
						lastm_q <= idx_q;
					end
					if (idx_last) begin
						if (found_q || match) begin
							idx_q   <= '0;
							state_q <= pftr_pkg::S_FORCE;
						end else begin
							strobe_q <= 1'b1;
							res_q    <= mk_res(pftr_pkg::ST_ABSENT, pftr_pkg::ACT_NONE, '0,
								page_q, 1'b1);
							state_q  <= pftr_pkg::S_IDLE;
						end
					end else begin
						idx_q <= idx_inc;
					end
				end
				pftr_pkg::S_FORCE: begin
					if (match) begin
						fdirty_q[idx_q] <= 1'b0;
						wb_cnt_q <= wb_cnt_q + 32'd1;
						strobe_q <= 1'b1;
						res_q    <= mk_res(pftr_pkg::ST_OK, pftr_pkg::ACT_WBACK, idx_q,
							fpage_q[idx_q], idx_q == lastm_q);
					end
					if (idx_q == lastm_q) begin
						state_q <= pftr_pkg::S_IDLE;
					end else begin
						idx_q <= idx_inc;
					end
				end
				pftr_pkg::S_FLUSH: begin
					if (fdirty_q[idx_q] && unpinned) begin
						fdirty_q[idx_q] <= 1'b0;
						wb_cnt_q  <= wb_cnt_q + 32'd1;
						written_q <= 1'b1;
						strobe_q  <= 1'b1;
						res_q     <= mk_res(pftr_pkg::ST_OK, pftr_pkg::ACT_WBACK, idx_q,
							fpage_q[idx_q], 1'b0);
					end
					if (!unpinned) begin
						failed_q <= 1'b1;
						state_q  <= pftr_pkg::S_FINAL;
					end else if (idx_last) begin
						state_q <= pftr_pkg::S_FINAL;
					end else begin
						idx_q <= idx_inc;
					end
				end
				pftr_pkg::S_FINAL: begin
					strobe_q <= 1'b1;
					res_q    <= mk_res((failed_q || !written_q) ? pftr_pkg::ST_FLUSHERR :
						pftr_pkg::ST_OK, pftr_pkg::ACT_NONE, '0, '0, 1'b1);
					state_q  <= pftr_pkg::S_IDLE;
				end
				default: state_q <= pftr_pkg::S_IDLE;
			endcase
		end
	end

	assign busy          = (state_q != pftr_pkg::S_IDLE);
	assign result_strobe = strobe_q;
	assign status        = res_q.status;
	assign action        = res_q.action;
	assign frame_index   = res_q.frame;
	assign io_page       = res_q.page;
	assign is_last       = res_q.last;
	assign reads_done    = fetch_cnt_q;
	assign writes_done   = wb_cnt_q;

endmodule

// ===== sv/pftr_divmod.sv =====
// ----------------------------------------------------------------------------
// pftr_divmod: iterative remainder unit
// Restoring division of a 32-bit count by the active frame count, one bit
// per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module pftr_divmod #(
	parameter int FRAMES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pftr_pkg::div_req_t            req,
	input  logic [$clog2(FRAMES+1)-1:0]   divisor,
	output logic                          done,
	output logic [$clog2(FRAMES)-1:0]     remainder
);

	localparam int NW = $clog2(FRAMES + 1);
	localparam int FW = $clog2(FRAMES);

	logic [31:0]   dvd_q;
	logic [NW-1:0] rem_q;
	logic [5:0]    cnt_q;
	logic          run_q;
	logic          done_q;
	logic [NW:0]   trial;

	assign trial = {rem_q, dvd_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				rem_q <= NW'(trial - {1'b0, divisor});
			end else begin
				rem_q <= trial[NW-1:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q[FW-1:0];

endmodule
